// File: sv/fvn_pkg.sv
`timescale 1ns / 1ps

package fvn_pkg;

    localparam int POS_W = 48;  // lattice position: 32 bit cell index, 16 bit fraction
    localparam int ACC_W = 34;  // octave sum, Q.30
    localparam int RCP_W = 17;  // Q.16 reciprocal of total amplitude
    localparam int CNT_W = 5;   // effective octave count, 1 up to the core's MAX_OCTAVES

    localparam logic [31:0] HASH_X   = 32'd374761393;
    localparam logic [31:0] HASH_Z   = 32'd668265263;
    localparam logic [31:0] HASH_MIX = 32'd1274126177;
    localparam int          HASH_SH  = 13;
    localparam logic [31:0] SEED_STEP = 32'd1000;

    localparam int CELL_LAT = 4;

    typedef enum logic [7:0] {
        REG_SEED  = 8'd0,
        REG_FREQ  = 8'd1,
        REG_BASE  = 8'd2,
        REG_AMP   = 8'd3,
        REG_MODE  = 8'd4,
        REG_OCT   = 8'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]      seed;
        logic             fractal;
        logic [CNT_W-1:0] oct_cnt;
    } cell_cfg_t;

    // round(2^(k+15) / (2^k - 1))
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] k);
        logic [RCP_W-1:0] r;
        unique case (k)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd43691;
            5'd3:    r = 17'd37449;
            5'd4:    r = 17'd34953;
            5'd5:    r = 17'd33825;
            5'd6:    r = 17'd33288;
            5'd7:    r = 17'd33026;
            5'd8:    r = 17'd32897;
            5'd9:    r = 17'd32832;
            5'd10:   r = 17'd32800;
            5'd11:   r = 17'd32784;
            5'd12:   r = 17'd32776;
            5'd13:   r = 17'd32772;
            5'd14:   r = 17'd32770;
            5'd15:   r = 17'd32769;
            5'd16:   r = 17'd32769;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// File: sv/fractal_value_noise_height_core.sv
`timescale 1ns / 1ps
// Fractal value-noise terrain height.
// Input channel s_valid/s_ready carries one request: s_world_x, s_world_z
// (signed integer coordinates). Result channel m_valid/m_ready returns one
// signed Q16.16 height per request, in request order.
// Configuration channel cfg_valid/cfg_ready writes cfg_data to register
// cfg_index (0 seed, 1 frequency, 2 base height, 3 amplitude, 4 mode,
// 5 octave count); other indexes are dropped. cfg_ready is always high;
// write only while no request is in flight.
// Pipeline: one front multiply stage loaded at the accepting edge,
// four stages per octave cell and three output stages (normalize,
// scale, saturate).
// Throughput: one request per cycle while the output is not stalled, set
// by the chain of octave cells, each of which takes a new request every cycle.
// Reset clears all valid flags and loads the register defaults.
// When the receiver stalls, the whole pipeline holds in place and
// s_ready drops until the result at the output is taken.
module fractal_value_noise_height_core #(
    parameter int MAX_OCTAVES = 8,
    parameter int COORD_BITS  = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_world_x,
    input  logic signed [COORD_BITS-1:0] s_world_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_surface_height,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);

    localparam int LAT = 4 + fvn_pkg::CELL_LAT * MAX_OCTAVES;
    localparam int PW  = fvn_pkg::POS_W;
    localparam int AW  = fvn_pkg::ACC_W;

    // configuration registers
    logic [31:0]        seed_reg;
    logic [23:0]        freq_reg;
    logic signed [31:0] base_reg;
    logic signed [31:0] amp_reg;
    logic               mode_reg;
    logic [3:0]         oct_reg;

    logic                      en;
    logic [LAT-1:0]            vld_reg, vld_next;
    logic [fvn_pkg::CNT_W-1:0] k_eff;
    fvn_pkg::cell_cfg_t        cell_cfg;

    logic [PW-1:0]        px_reg, pz_reg;
    logic [PW-1:0]        px_chain [0:MAX_OCTAVES];
    logic [PW-1:0]        pz_chain [0:MAX_OCTAVES];
    logic signed [AW-1:0] acc_chain [0:MAX_OCTAVES];

    logic signed [AW+18:0] nprod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW+18:0] nshift;
    logic signed [15:0]    noise;
    logic signed [47:0]    hprod_reg;
    logic signed [33:0]    hsum;
    logic signed [31:0]    height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
            freq_reg <= 24'd655;
            base_reg <= 32'sd4194304;
            amp_reg  <= 32'sd2097152;
            mode_reg <= 1'b0;
            oct_reg  <= 4'd4;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fvn_pkg::REG_SEED: seed_reg <= cfg_data;
                fvn_pkg::REG_FREQ: freq_reg <= cfg_data[23:0];
                fvn_pkg::REG_BASE: base_reg <= $signed(cfg_data);
                fvn_pkg::REG_AMP:  amp_reg  <= $signed(cfg_data);
                fvn_pkg::REG_MODE: mode_reg <= cfg_data[0];
                fvn_pkg::REG_OCT:  oct_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamp octave count to 1..MAX_OCTAVES
    always_comb begin
        if (oct_reg == 4'd0) begin
            k_eff = fvn_pkg::CNT_W'(1);
        end else if (fvn_pkg::CNT_W'(oct_reg) > fvn_pkg::CNT_W'(MAX_OCTAVES)) begin
            k_eff = fvn_pkg::CNT_W'(MAX_OCTAVES);
        end else begin
            k_eff = fvn_pkg::CNT_W'(oct_reg);
        end
    end

    assign cell_cfg = '{seed: seed_reg, fractal: mode_reg, oct_cnt: k_eff};

    // advance the whole pipeline unless the output holds an untaken result
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], s_valid && s_ready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // front: coordinate times base frequency, kept modulo 2^48
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= PW'(PW'(s_world_x) * $signed({24'd0, freq_reg}));
            pz_reg <= PW'(PW'(s_world_z) * $signed({24'd0, freq_reg}));
        end
    end

    assign px_chain[0]  = px_reg;
    assign pz_chain[0]  = pz_reg;
    assign acc_chain[0] = '0;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
        fvn_octave_cell #(.OCT_IDX(i)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .cfg     (cell_cfg),
            .px_in   (px_chain[i]),
            .pz_in   (pz_chain[i]),
            .acc_in  (acc_chain[i]),
            .px_out  (px_chain[i+1]),
            .pz_out  (pz_chain[i+1]),
            .acc_out (acc_chain[i+1])
        );
    end

    // normalize: fractal sum times reciprocal, single mode passes octave 0
    assign nshift = nprod_reg >>> 31;

    always_comb begin
        if (!mode_reg) begin
            noise = 16'(acc_reg >>> 15);
        end else if (nshift > 53'sd32767) begin
            noise = 16'sd32767;
        end else if (nshift < -53'sd32768) begin
            noise = -16'sd32768;
        end else begin
            noise = nshift[15:0];
        end
    end

    assign hsum = 34'(base_reg) + 34'(hprod_reg >>> 15);

    always_ff @(posedge aclk) begin
        if (en) begin
            nprod_reg <= (AW + 19)'(acc_chain[MAX_OCTAVES]) *
                         $signed({{(AW + 19 - fvn_pkg::RCP_W){1'b0}}, fvn_pkg::recip(k_eff)});
            acc_reg   <= acc_chain[MAX_OCTAVES];
            hprod_reg <= 48'(noise) * 48'(amp_reg);
            if (hsum > 34'sd2147483647) begin
                height_reg <= 32'sh7FFFFFFF;
            end else if (hsum < -34'sd2147483648) begin
                height_reg <= 32'sh80000000;
            end else begin
                height_reg <= hsum[31:0];
            end
        end
    end

    assign m_surface_height = height_reg;

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_surface_height))
        else $error("stalled result changed");
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request accepted while output stalled");
    a_zero_amp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && amp_reg == 32'sd0 |-> m_surface_height == base_reg)
        else $error("zero amplitude height differs from base");
`endif

endmodule

// File: sv/fvn_octave_cell.sv
`timescale 1ns / 1ps

module fvn_octave_cell #(
    parameter int OCT_IDX = 0
) (
    input  logic                             aclk,
    input  logic                             en,
    input  fvn_pkg::cell_cfg_t               cfg,
    input  logic [fvn_pkg::POS_W-1:0]        px_in,
    input  logic [fvn_pkg::POS_W-1:0]        pz_in,
    input  logic signed [fvn_pkg::ACC_W-1:0] acc_in,
    output logic [fvn_pkg::POS_W-1:0]        px_out,
    output logic [fvn_pkg::POS_W-1:0]        pz_out,
    output logic signed [fvn_pkg::ACC_W-1:0] acc_out
);

    function automatic logic [17:0] smooth(input logic [15:0] t2, input logic [15:0] t);
        logic [17:0] w;
        logic [33:0] p;
        w = 18'd196608 - {1'b0, t, 1'b0};
        p = 34'(t2) * 34'(w);
        return p[33:16];
    endfunction

    function automatic logic [15:0] corner(input logic [31:0] h);
        logic [31:0] m;
        logic [15:0] v;
        m = h ^ (h >> fvn_pkg::HASH_SH);
        v = m[15:0] * fvn_pkg::HASH_MIX[15:0];
        return {~v[15], v[14:0]};
    endfunction

    function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [17:0] s);
        logic signed [16:0] d;
        logic signed [36:0] p;
        logic signed [36:0] r;
        d = 17'(b) - 17'(a);
        p = 37'(d) * $signed({19'd0, s});
        r = 37'(a) + (p >>> 16);
        return r[15:0];
    endfunction

    logic [fvn_pkg::POS_W-1:0] pxs, pzs;
    logic [31:0] seed;
    logic [fvn_pkg::CNT_W-1:0] k_eff;
    logic active;

    // stage a: hash products and squared fractions
    logic [31:0] ax_reg, az_reg;
    logic [15:0] tx_reg, tz_reg, tx2_reg, tz2_reg;
    logic [31:0] txx, tzz;
    // stage b: corner values and smoothstep weights
    logic [15:0] n00_reg, n10_reg, n01_reg, n11_reg;
    logic [17:0] sx_reg, sz_b_reg, sz_c_reg;
    // stage c: row blends
    logic signed [15:0] n0_reg, n1_reg;
    logic signed [15:0] nv;

    logic [fvn_pkg::POS_W-1:0] px_a_reg, px_b_reg, px_c_reg, px_d_reg;
    logic [fvn_pkg::POS_W-1:0] pz_a_reg, pz_b_reg, pz_c_reg, pz_d_reg;
    logic signed [fvn_pkg::ACC_W-1:0] acc_a_reg, acc_b_reg, acc_c_reg, acc_d_reg;

    assign pxs = px_in << OCT_IDX;
    assign pzs = pz_in << OCT_IDX;
    assign txx = 32'(pxs[15:0]) * 32'(pxs[15:0]);
    assign tzz = 32'(pzs[15:0]) * 32'(pzs[15:0]);

    assign k_eff  = cfg.oct_cnt;
    assign seed   = (OCT_IDX == 0) ? (cfg.fractal ? 32'd0 : cfg.seed)
                  : (cfg.seed ^ (cfg.seed + fvn_pkg::SEED_STEP * 32'(OCT_IDX)));
    assign active = cfg.fractal ? (fvn_pkg::CNT_W'(OCT_IDX) < k_eff) : (OCT_IDX == 0);

    assign nv = lerp(n0_reg, n1_reg, sz_c_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg   <= pxs[47:16] * fvn_pkg::HASH_X;
            az_reg   <= pzs[47:16] * fvn_pkg::HASH_Z;
            tx_reg   <= pxs[15:0];
            tz_reg   <= pzs[15:0];
            tx2_reg  <= txx[31:16];
            tz2_reg  <= tzz[31:16];

            n00_reg  <= corner(seed ^ ax_reg ^ az_reg);
            n10_reg  <= corner(seed ^ (ax_reg + fvn_pkg::HASH_X) ^ az_reg);
            n01_reg  <= corner(seed ^ ax_reg ^ (az_reg + fvn_pkg::HASH_Z));
            n11_reg  <= corner(seed ^ (ax_reg + fvn_pkg::HASH_X) ^ (az_reg + fvn_pkg::HASH_Z));
            sx_reg   <= smooth(tx2_reg, tx_reg);
            sz_b_reg <= smooth(tz2_reg, tz_reg);

            n0_reg   <= lerp($signed(n00_reg), $signed(n10_reg), sx_reg);
            n1_reg   <= lerp($signed(n01_reg), $signed(n11_reg), sx_reg);
            sz_c_reg <= sz_b_reg;

            acc_d_reg <= acc_c_reg + (active ?
                         (fvn_pkg::ACC_W'(nv) <<< (15 - OCT_IDX)) : '0);

            px_a_reg <= px_in;    pz_a_reg <= pz_in;    acc_a_reg <= acc_in;
            px_b_reg <= px_a_reg; pz_b_reg <= pz_a_reg; acc_b_reg <= acc_a_reg;
            px_c_reg <= px_b_reg; pz_c_reg <= pz_b_reg; acc_c_reg <= acc_b_reg;
            px_d_reg <= px_c_reg; pz_d_reg <= pz_c_reg;
        end
    end

    assign px_out  = px_d_reg;
    assign pz_out  = pz_d_reg;
    assign acc_out = acc_d_reg;

endmodule

// File: dv/fvn_height_checker.sv
`timescale 1ns / 1ps

module fvn_height_checker #(
    parameter int MAX_OCTAVES = 8,
    parameter int COORD_BITS  = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_world_x,
    input  logic signed [COORD_BITS-1:0] s_world_z,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [31:0]           m_surface_height,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [7:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    output int                           fails,
    output int                           pending
);

    logic [31:0]        seed_q;
    logic [23:0]        freq_q;
    logic signed [31:0] base_q;
    logic signed [31:0] amp_q;
    logic               fractal_q;
    logic [3:0]         oct_q;

    logic signed [31:0] height_q[$];
    int                 n_seen;

    function automatic longint smoothstep(longint t);
        longint t2;
        t2 = (t * t) >>> 16;
        return (t2 * (196608 - 2 * t)) >>> 16;
    endfunction

    function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cz,
                                             logic [31:0] sd);
        logic [31:0] h;
        h = sd;
        h = h ^ (cx * fvn_pkg::HASH_X);
        h = h ^ (cz * fvn_pkg::HASH_Z);
        h = (h ^ (h >> fvn_pkg::HASH_SH)) * fvn_pkg::HASH_MIX;
        return longint'({48'd0, h[15:0]}) - 32768;
    endfunction

    function automatic longint lerp_q15(longint a, longint b, longint s);
        return a + (((b - a) * s) >>> 16);
    endfunction

    function automatic longint value_noise(longint wx, longint wz, longint f,
                                           logic [31:0] sd);
        logic [63:0] px, pz;
        logic [31:0] cx, cz;
        longint      sx, sz, n0, n1;
        px = wx * f;
        pz = wz * f;
        cx = px[47:16];
        cz = pz[47:16];
        sx = smoothstep(longint'({48'd0, px[15:0]}));
        sz = smoothstep(longint'({48'd0, pz[15:0]}));
        n0 = lerp_q15(lattice_value(cx, cz, sd), lattice_value(cx + 1, cz, sd), sx);
        n1 = lerp_q15(lattice_value(cx, cz + 1, sd),
                      lattice_value(cx + 1, cz + 1, sd), sx);
        return lerp_q15(n0, n1, sz);
    endfunction

    function automatic logic signed [31:0] terrain_height(longint wx, longint wz);
        longint      noise, acc, den, rcp, h;
        int          k;
        logic [31:0] sd;
        if (!fractal_q) begin
            noise = value_noise(wx, wz, longint'(freq_q), seed_q);
        end else begin
            k = oct_q;
            if (k < 1) k = 1;
            if (k > MAX_OCTAVES) k = MAX_OCTAVES;
            acc = 0;
            for (int i = 0; i < k; i++) begin
                sd = seed_q ^ (seed_q + fvn_pkg::SEED_STEP * i);
                acc += value_noise(wx, wz, longint'(freq_q) << i, sd) * (64'sd1 << (15 - i));
            end
            den = (64'sd1 << k) - 1;
            rcp = ((64'sd1 << (k + 15)) + den / 2) / den;
            noise = (acc * rcp) >>> 31;
            if (noise > 32767) noise = 32767;
            if (noise < -32768) noise = -32768;
        end
        h = longint'(base_q) + ((noise * longint'(amp_q)) >>> 15);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ERROR %s", $realtime, what);
        fails++;
    endtask

    assign pending = height_q.size();

    initial fails = 0;

    always @(posedge aclk) begin
        logic signed [31:0] want;
        if (!aresetn) begin
            seed_q    <= 32'd0;
            freq_q    <= 24'd655;
            base_q    <= 32'sd4194304;
            amp_q     <= 32'sd2097152;
            fractal_q <= 1'b0;
            oct_q     <= 4'd4;
            height_q.delete();
            n_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (fvn_pkg::reg_idx_t'(cfg_index))
                    fvn_pkg::REG_SEED: seed_q    <= cfg_data;
                    fvn_pkg::REG_FREQ: freq_q    <= cfg_data[23:0];
                    fvn_pkg::REG_BASE: base_q    <= cfg_data;
                    fvn_pkg::REG_AMP:  amp_q     <= cfg_data;
                    fvn_pkg::REG_MODE: fractal_q <= cfg_data[0];
                    fvn_pkg::REG_OCT:  oct_q     <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                height_q.push_back(terrain_height(longint'(s_world_x), longint'(s_world_z)));
            if (m_valid && m_ready) begin
                n_seen++;
                if (height_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected height %0d", m_surface_height));
                end else begin
                    want = height_q.pop_front();
                    if (m_surface_height !== want)
                        report_mismatch($sformatf("height #%0d got %0d want %0d",
                                                  n_seen, m_surface_height, want));
                end
            end
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CB        = 24;
    localparam int WDOG_MAX  = 5000;
    localparam int DRAIN_CYC = 60;   // longer than the whole pipeline
    localparam int N_PHASES  = 8;
    localparam int PER_PHASE = 70;

    // idle schemes, rotated per phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_DST  = 2;
    localparam int IDLE_BOTH = 3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CB-1:0] s_world_x;
    logic signed [CB-1:0] s_world_z;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [31:0]   m_surface_height;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [7:0]           cfg_index;
    logic [31:0]          cfg_data;

    int fails;
    int pending;
    int idle_mode;
    int n_sent;
    int quiet_cycles;

    fractal_value_noise_height_core dut (.*);

    fvn_height_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_world_x(s_world_x), .s_world_z(s_world_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_surface_height(m_surface_height),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: stall according to the current idle scheme.
    always @(negedge aclk) begin
        case (idle_mode)
            IDLE_DST:  m_ready <= ($urandom_range(99) >= 57);
            IDLE_BOTH: m_ready <= ($urandom_range(99) >= 17);
            default:   m_ready <= 1'b1;
        endcase
    end

    // Watchdog: count cycles with no request, height or register write moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d heights outstanding", pending);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Write one register; caller sits on a falling edge.
    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Present one request, idling first if the scheme says so; hold until taken.
    task automatic send_coord(logic signed [CB-1:0] x, logic signed [CB-1:0] z);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SRC) ? 57 : (idle_mode == IDLE_BOTH) ? 17 : 0;
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_world_x <= x;
        s_world_z <= z;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_sent++;
    endtask

    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(2))
            0:       return CB'($urandom);
            1:       return CB'($signed($urandom_range(600)) - 300);
            default: return $urandom_range(1) ? CB'(-(1 << (CB-1)) + $urandom_range(40))
                                              : CB'((1 << (CB-1)) - 1 - $urandom_range(40));
        endcase
    endfunction

    // Drop valid, wait for every height, then let the pipe go quiet.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    task automatic load_cfg(logic [31:0] sd, logic [23:0] fr, logic [31:0] bh,
                            logic [31:0] am, logic fm, logic [3:0] oc);
        write_reg(fvn_pkg::REG_SEED, sd);
        write_reg(fvn_pkg::REG_FREQ, {8'($urandom), fr});
        write_reg(fvn_pkg::REG_BASE, bh);
        write_reg(fvn_pkg::REG_AMP, am);
        write_reg(fvn_pkg::REG_MODE, {31'($urandom), fm});
        write_reg(fvn_pkg::REG_OCT, {28'($urandom), oc});
        // indexes past the register list must be dropped
        write_reg(8'd6, $urandom);
        write_reg(8'hFF, $urandom);
    endtask

    logic signed [CB-1:0] edge_vals[5];
    int                   ok;

    initial begin
        edge_vals = '{CB'(-(1 << (CB-1))), CB'((1 << (CB-1)) - 1), CB'(0), CB'(-1), CB'(1)};
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_world_x = '0;
        s_world_z = '0;
        m_ready   = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_mode = IDLE_NONE;
        n_sent    = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int p = 0; p < N_PHASES; p++) begin
            // phase 0 runs on the reset values
            case (p)
                1: load_cfg($urandom, 24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 4'd8);
                2: load_cfg($urandom, 24'd0, 32'h80000000, 32'h80000000, 1'b1, 4'd0);
                3: load_cfg($urandom, 24'($urandom_range(4000)), $urandom, 32'd0, 1'b1, 4'd15);
                4: load_cfg($urandom, 24'($urandom), $urandom, $urandom, 1'b0, 4'($urandom));
                5: load_cfg($urandom, 24'($urandom_range(70000)), $urandom, $urandom,
                            1'b1, 4'($urandom_range(1, 8)));
                6: load_cfg(32'hFFFFFFFF, 24'd655, 32'h80000000, 32'h7FFFFFFF, 1'b1, 4'd4);
                7: load_cfg(32'd0, 24'hFFFFFF, 32'd4194304, 32'd2097152, 1'b0, 4'd9);
                default: ;
            endcase
            idle_mode = p % 4;
            // corners and sign boundaries of the coordinate space
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j += 2)
                    send_coord(edge_vals[i], edge_vals[(i + j) % 5]);
            for (int n = 15; n < PER_PHASE; n++) begin
                if (p == 3 && n == PER_PHASE / 2) begin
                    // hold the sender until the pipe has emptied
                    s_valid <= 1'b0;
                    while (pending != 0) @(negedge aclk);
                end
                send_coord(pick_coord(), pick_coord());
            end
            drain();
        end

        ok = (fails == 0) && (pending == 0);
        $display("sent %0d requests over %0d register settings", n_sent, N_PHASES);
        $display("single and octave modes, saturating extremes, all four idle schemes");
        if (ok) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
